[sv/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg: shared constants of the timer slot scheduler
// Field widths, command, policy and status codes, saturating time add.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int TIME_W = 63;
  localparam int ID_W   = 32;
  localparam int IVL_W  = 40;
  localparam int CMD_W  = 2;
  localparam int POL_W  = 2;
  localparam int STS_W  = 2;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int TAG_BITS_DEF   = 16;
  localparam int MAX_RES        = 32;
  localparam int RES_CNT_W      = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W      = $clog2(MAX_RES);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd3;

  localparam logic [POL_W-1:0] POL_ONCE  = 2'd0;
  localparam logic [POL_W-1:0] POL_FIXED = 2'd1;

  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd1;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd2;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [IVL_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W+1-IVL_W){1'b0}}, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

[sv/timer_slot_scheduler.sv]
// ----------------------------------------------------------------------------
// timer_slot_scheduler: fixed table of timer slots
// Add, modify, remove and run-due commands over a slot table, reporting
// fired tags and the earliest due time.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tuser command, tdata timer fields
//  m_axis    out  tvalid/tready/tlast       tdata result fields
//
//  add scans the slots in order for a free one; modify and remove read and
//  check each slot in turn until the id matches, run checks every slot; a
//  minimum scan then reads every slot, and each result is read from the tag
//  buffer. fixed-rate re-arms wait on the serial remainder unit. one memory
//  read port sets the scan pace. reset clears valid bits and the id counter
//  at once. s_axis_tready_o is high only while idle; a stalled m_axis holds
//  the sequencer in the output state.
module timer_slot_scheduler #(
  parameter int SLOT_COUNT = tss_pkg::SLOT_COUNT_DEF,
  parameter int TAG_BITS   = tss_pkg::TAG_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // command
  input  logic [tss_pkg::CMD_W-1:0]         s_axis_tuser_i,
  // now_time, timer_id, interval_ticks, has_base, base_time, policy, callback_tag
  input  logic [((201+TAG_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // status, assigned_id, fired, fired_tag, earliest_due
  output logic [((98+TAG_BITS+7)/8)*8-1:0]  m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import tss_pkg::*;

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int OUT_DW = ((98 + TAG_BITS + 7) / 8) * 8;
  localparam int O_ID   = TIME_W;
  localparam int O_IVL  = O_ID + ID_W;
  localparam int O_HB   = O_IVL + IVL_W;
  localparam int O_BASE = O_HB + 1;
  localparam int O_POL  = O_BASE + TIME_W;
  localparam int O_TAG  = O_POL + POL_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ADD  = 4'd1;
  localparam logic [3:0] ST_RD   = 4'd2;
  localparam logic [3:0] ST_EV   = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_MRD  = 4'd5;
  localparam logic [3:0] ST_MEV  = 4'd6;
  localparam logic [3:0] ST_ORD  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [IDX_W-1:0]    last_idx;
  assign last_idx = IDX_W'(SLOT_COUNT - 1);

  // slot table
  logic [ID_W-1:0]     mem_id  [SLOT_COUNT];
  logic [TAG_BITS-1:0] mem_tag [SLOT_COUNT];
  logic [TIME_W-1:0]   mem_due [SLOT_COUNT];
  logic [IVL_W-1:0]    mem_ivl [SLOT_COUNT];
  logic [POL_W-1:0]    mem_pol [SLOT_COUNT];
  logic [TAG_BITS-1:0] res_buf [MAX_RES];

  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [3:0]          state_q, state_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [ID_W-1:0]     ctr_q, ctr_d;
  logic [RES_CNT_W-1:0] nfire_q, nfire_d;
  logic [RES_CNT_W-1:0] k_q, k_d;
  logic [TIME_W-1:0]   min_q, min_d;
  logic [STS_W-1:0]    sts_q, sts_d;
  logic [ID_W-1:0]     aid_q, aid_d;

  logic [CMD_W-1:0]    cmd_q;
  logic [TIME_W-1:0]   now_q;
  logic [ID_W-1:0]     tid_q;
  logic [IVL_W-1:0]    ivl_q;
  logic                hb_q;
  logic [TIME_W-1:0]   base_q;
  logic [POL_W-1:0]    pol_q;
  logic [TAG_BITS-1:0] tag_q;

  logic [ID_W-1:0]     rd_id_q;
  logic [TAG_BITS-1:0] rd_tag_q;
  logic [TIME_W-1:0]   rd_due_q;
  logic [IVL_W-1:0]    rd_ivl_q;
  logic [POL_W-1:0]    rd_pol_q;
  logic [TAG_BITS-1:0] buf_rd_q;

  logic                o_valid_q, o_valid_d;
  logic                o_last_q, o_last_d;
  logic [STS_W-1:0]    o_sts_q, o_sts_d;
  logic [ID_W-1:0]     o_aid_q, o_aid_d;
  logic                o_fired_q, o_fired_d;
  logic [TAG_BITS-1:0] o_tag_q, o_tag_d;
  logic [TIME_W-1:0]   o_min_q, o_min_d;

  // write port controls
  logic                we_full, we_due, we_cfg, buf_we;
  logic [TIME_W-1:0]   wr_due;
  logic [IDX_W-1:0]    ia;

  logic                div_start, div_done;
  logic [IVL_W-1:0]    div_rem;
  logic [TIME_W-1:0]   base_eff;
  logic                vld, hit, due_now;
  logic                run_fire;
  logic [RES_CNT_W-1:0] n_res;

  assign ia       = idx_q[IDX_W-1:0];
  assign base_eff = hb_q ? base_q : now_q;
  assign vld      = valid_q[ia];
  assign hit      = vld && (rd_id_q == tid_q);
  assign due_now  = vld && (rd_due_q <= now_q) && (nfire_q != RES_CNT_W'(MAX_RES));
  assign run_fire = (cmd_q == CMD_RUN) && (nfire_q != '0);
  assign n_res    = run_fire ? nfire_q : RES_CNT_W'(1);

  tss_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (now_q - rd_due_q),
    .divisor_i  (rd_ivl_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    valid_d   = valid_q;
    ctr_d     = ctr_q;
    nfire_d   = nfire_q;
    k_d       = k_q;
    min_d     = min_q;
    sts_d     = sts_q;
    aid_d     = aid_q;
    we_full   = 1'b0;
    we_due    = 1'b0;
    we_cfg    = 1'b0;
    buf_we    = 1'b0;
    wr_due    = sat_add(base_eff, ivl_q);
    div_start = 1'b0;
    o_valid_d = o_valid_q && !m_axis_tready_i;
    o_last_d  = o_last_q;
    o_sts_d   = o_sts_q;
    o_aid_d   = o_aid_q;
    o_fired_d = o_fired_q;
    o_tag_d   = o_tag_q;
    o_min_d   = o_min_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          idx_d   = '0;
          nfire_d = '0;
          k_d     = '0;
          min_d   = TIME_MAX;
          sts_d   = STS_OK;
          aid_d   = '0;
          state_d = (s_axis_tuser_i == CMD_ADD) ? ST_ADD : ST_RD;
        end
      end
      ST_ADD: begin
        if (!vld) begin
          we_full = 1'b1;
          if (pol_q == POL_ONCE && hb_q) begin
            wr_due = base_q;
          end
          valid_d[ia] = 1'b1;
          ctr_d   = ctr_q + 1'b1;
          aid_d   = ctr_q + 1'b1;
          idx_d   = '0;
          state_d = ST_MRD;
        end else if (ia == last_idx) begin
          sts_d   = STS_FULL;
          idx_d   = '0;
          state_d = ST_MRD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RD: begin
        state_d = ST_EV;
      end
      ST_EV: begin
        if (cmd_q != CMD_RUN) begin
          if (hit) begin
            if (cmd_q == CMD_MODIFY) begin
              we_cfg = 1'b1;
              we_due = 1'b1;
            end else begin
              valid_d[ia] = 1'b0;
            end
            idx_d   = '0;
            state_d = ST_MRD;
          end else if (ia == last_idx) begin
            sts_d   = STS_NOT_FOUND;
            idx_d   = '0;
            state_d = ST_MRD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_RD;
          end
        end else begin
          if (due_now) begin
            buf_we  = 1'b1;
            nfire_d = nfire_q + 1'b1;
          end
          if (due_now && rd_pol_q == POL_FIXED && rd_ivl_q != '0) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            if (due_now) begin
              if (rd_pol_q == POL_ONCE) begin
                valid_d[ia] = 1'b0;
              end else begin
                we_due = 1'b1;
                wr_due = (rd_pol_q == POL_FIXED) ? now_q : sat_add(now_q, rd_ivl_q);
              end
            end
            if (ia == last_idx) begin
              idx_d   = '0;
              state_d = ST_MRD;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = ST_RD;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          we_due = 1'b1;
          wr_due = sat_add(now_q - {{(TIME_W-IVL_W){1'b0}}, div_rem}, rd_ivl_q);
          if (ia == last_idx) begin
            idx_d   = '0;
            state_d = ST_MRD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end
      ST_MRD: begin
        state_d = ST_MEV;
      end
      ST_MEV: begin
        if (vld && rd_due_q < min_q) begin
          min_d = rd_due_q;
        end
        if (ia == last_idx) begin
          state_d = ST_ORD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_MRD;
        end
      end
      ST_ORD: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!o_valid_q || m_axis_tready_i) begin
          o_valid_d = 1'b1;
          o_sts_d   = sts_q;
          o_aid_d   = aid_q;
          o_fired_d = run_fire;
          o_tag_d   = run_fire ? buf_rd_q : '0;
          o_min_d   = min_q;
          o_last_d  = (k_q == n_res - 1'b1);
          if (k_q == n_res - 1'b1) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_ORD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      valid_q   <= '0;
      ctr_q     <= '0;
      nfire_q   <= '0;
      k_q       <= '0;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      valid_q   <= valid_d;
      ctr_q     <= ctr_d;
      nfire_q   <= nfire_d;
      k_q       <= k_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q     <= min_d;
    sts_q     <= sts_d;
    aid_q     <= aid_d;
    o_last_q  <= o_last_d;
    o_sts_q   <= o_sts_d;
    o_aid_q   <= o_aid_d;
    o_fired_q <= o_fired_d;
    o_tag_q   <= o_tag_d;
    o_min_q   <= o_min_d;
    if (state_q == ST_IDLE && s_axis_tvalid_i) begin
      cmd_q  <= s_axis_tuser_i;
      now_q  <= s_axis_tdata_i[TIME_W-1:0];
      tid_q  <= s_axis_tdata_i[O_ID +: ID_W];
      ivl_q  <= s_axis_tdata_i[O_IVL +: IVL_W];
      hb_q   <= s_axis_tdata_i[O_HB];
      base_q <= s_axis_tdata_i[O_BASE +: TIME_W];
      pol_q  <= s_axis_tdata_i[O_POL +: POL_W];
      tag_q  <= s_axis_tdata_i[O_TAG +: TAG_BITS];
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_full) begin
      mem_id[ia]  <= ctr_q + 1'b1;
      mem_tag[ia] <= tag_q;
    end
    if (we_full || we_cfg) begin
      mem_ivl[ia] <= ivl_q;
      mem_pol[ia] <= pol_q;
    end
    if (we_full || we_due) begin
      mem_due[ia] <= wr_due;
    end
    if (state_q == ST_RD || state_q == ST_MRD) begin
      rd_id_q  <= mem_id[ia];
      rd_tag_q <= mem_tag[ia];
      rd_due_q <= mem_due[ia];
      rd_ivl_q <= mem_ivl[ia];
      rd_pol_q <= mem_pol[ia];
    end
  end

  // fired tag buffer
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      res_buf[nfire_q[RES_IDX_W-1:0]] <= rd_tag_q;
    end
    if (state_q == ST_ORD) begin
      buf_rd_q <= res_buf[k_q[RES_IDX_W-1:0]];
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tdata_o  = OUT_DW'({o_min_q, o_tag_q, o_fired_q, o_aid_q, o_sts_q});

endmodule

[sv/tss_mod.sv]
// ----------------------------------------------------------------------------
// tss_mod: bit-serial remainder unit
// Restoring division, one dividend bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module tss_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tss_pkg::TIME_W-1:0] dividend_i,
  input  logic [tss_pkg::IVL_W-1:0]  divisor_i,
  output logic                      done_o,
  output logic [tss_pkg::IVL_W-1:0]  rem_o
);
  import tss_pkg::*;

  localparam int CNT_W = $clog2(TIME_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [TIME_W-1:0] dvd_q, dvd_d;
  logic [IVL_W-1:0]  div_q, div_d;
  logic [IVL_W-1:0]  rem_q, rem_d;
  logic [IVL_W:0]    trial;

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[TIME_W-1]};
    if (start_i) begin
      cnt_d = CNT_W'(TIME_W);
      dvd_d = dividend_i;
      div_d = divisor_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = IVL_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[IVL_W-1:0];
      end
      dvd_d = {dvd_q[TIME_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[dv/timer_slot_scheduler_test.sv]
// ----------------------------------------------------------------------------
// timer_slot_scheduler_test: self-checking bench of the timer slot scheduler
// Drives add, modify, remove and run commands over the s_axis stream, models
// the slot table alongside, and checks every m_axis transaction field by
// field against the modeled results, with random idle and stall cycles.
// ----------------------------------------------------------------------------
module timer_slot_scheduler_test;
  import tss_pkg::*;

  localparam int NSLOT  = 32;
  localparam int TAG_W  = 16;
  localparam int IN_W   = ((201 + TAG_W + 7) / 8) * 8;
  localparam int OUT_W  = ((98 + TAG_W + 7) / 8) * 8;
  localparam int DOG_LIMIT = 20000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0]   id;
    logic [IVL_W-1:0]  ivl;
    logic              has_base;
    logic [TIME_W-1:0] base;
    logic [POL_W-1:0]  pol;
    logic [TAG_W-1:0]  tag;
  } timer_cmd_t;

  typedef struct packed {
    logic [STS_W-1:0]  sts;
    logic [ID_W-1:0]   aid;
    logic              fired;
    logic [TAG_W-1:0]  ftag;
    logic [TIME_W-1:0] due;
    logic              last;
  } timer_res_t;

  class slot_table_sb;
    bit                valid [NSLOT];
    logic [ID_W-1:0]   ids   [NSLOT];
    logic [TAG_W-1:0]  tags  [NSLOT];
    logic [TIME_W-1:0] dues  [NSLOT];
    logic [IVL_W-1:0]  ivls  [NSLOT];
    logic [POL_W-1:0]  pols  [NSLOT];
    logic [ID_W-1:0]   next_id;
    timer_res_t        pending[$];
    int                errors;

    function new();
      foreach (valid[i]) valid[i] = 0;
      next_id = '0;
      errors = 0;
    endfunction

    function logic [TIME_W-1:0] tadd(input logic [TIME_W-1:0] a,
                                      input logic [IVL_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + (TIME_W+1)'(b);
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    function int find_slot(input logic [ID_W-1:0] id);
      for (int i = 0; i < NSLOT; i++)
        if (valid[i] && ids[i] == id) return i;
      return -1;
    endfunction

    function void note_command(input timer_cmd_t c);
      timer_res_t        res[$];
      timer_res_t        r;
      logic [TIME_W-1:0] base, m;
      logic [63:0]       d, rem;
      int                k;
      base = c.has_base ? c.base : c.now;
      r = '0;
      r.last = 1'b1;
      case (c.cmd)
        CMD_ADD: begin
          k = -1;
          for (int i = NSLOT - 1; i >= 0; i--) if (!valid[i]) k = i;
          if (k < 0) r.sts = STS_FULL;
          else begin
            next_id++;
            valid[k] = 1; ids[k] = next_id; tags[k] = c.tag;
            ivls[k] = c.ivl; pols[k] = c.pol;
            dues[k] = (c.pol == POL_ONCE && c.has_base) ? base : tadd(base, c.ivl);
            r.aid = next_id;
          end
          res.push_back(r);
        end
        CMD_MODIFY: begin
          k = find_slot(c.id);
          if (k < 0) r.sts = STS_NOT_FOUND;
          else begin
            ivls[k] = c.ivl; pols[k] = c.pol; dues[k] = tadd(base, c.ivl);
          end
          res.push_back(r);
        end
        CMD_REMOVE: begin
          k = find_slot(c.id);
          if (k < 0) r.sts = STS_NOT_FOUND;
          else valid[k] = 0;
          res.push_back(r);
        end
        default: begin
          for (int i = 0; i < NSLOT && res.size() < MAX_RES; i++) begin
            if (!valid[i] || dues[i] > c.now) continue;
            if (pols[i] == POL_ONCE) valid[i] = 0;
            else if (pols[i] == POL_FIXED) begin
              if (ivls[i] == 0) dues[i] = c.now;
              else begin
                d = 64'(c.now) - 64'(dues[i]);
                rem = d % 64'(ivls[i]);
                dues[i] = tadd(c.now - rem[TIME_W-1:0], ivls[i]);
              end
            end else dues[i] = tadd(c.now, ivls[i]);
            r = '0;
            r.fired = 1'b1;
            r.ftag = tags[i];
            res.push_back(r);
          end
          if (res.size() == 0) begin
            r = '0;
            res.push_back(r);
          end
          res[res.size()-1].last = 1'b1;
        end
      endcase
      m = {TIME_W{1'b1}};
      for (int i = 0; i < NSLOT; i++) if (valid[i] && dues[i] < m) m = dues[i];
      foreach (res[j]) begin
        res[j].due = m;
        pending.push_back(res[j]);
      end
    endfunction

    function void check_result(input timer_res_t act);
      timer_res_t exp_r;
      if (pending.size() == 0) begin
        if (errors < 10) $display("unexpected result transaction: %p", act);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r !== act) begin
        if (errors < 10)
          $display("result mismatch: expected %p, actual %p", exp_r, act);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [CMD_W-1:0]  s_axis_tuser_i = '0;
  logic [IN_W-1:0]   s_axis_tdata_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata_o;
  logic              m_axis_tlast_o;

  slot_table_sb      sb;
  bit                calm;
  logic [TIME_W-1:0] clock_now;
  int                dog = 0;

  timer_slot_scheduler dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk_i) begin
    timer_res_t act;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      act.sts   = m_axis_tdata_o[1:0];
      act.aid   = m_axis_tdata_o[33:2];
      act.fired = m_axis_tdata_o[34];
      act.ftag  = m_axis_tdata_o[50:35];
      act.due   = m_axis_tdata_o[113:51];
      act.last  = m_axis_tlast_o;
      sb.check_result(act);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      dog <= 0;
    else dog <= dog + 1;
    if (dog >= DOG_LIMIT) begin
      $display("** timer_slot_scheduler: FAILED **");
      $finish;
    end
  end

  task automatic send_cmd(input timer_cmd_t c);
    while (!calm && $urandom_range(0, 99) < 22) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= c.cmd;
    s_axis_tdata_i  <= IN_W'({c.tag, c.pol, c.base, c.has_base, c.ivl, c.id, c.now});
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_command(c);
  endtask

  task automatic send_fields(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now,
                             input logic [ID_W-1:0] id, input logic [IVL_W-1:0] ivl,
                             input logic hb, input logic [TIME_W-1:0] base,
                             input logic [POL_W-1:0] pol, input logic [TAG_W-1:0] tag);
    timer_cmd_t c;
    c = '{cmd, now, id, ivl, hb, base, pol, tag};
    send_cmd(c);
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int live[$];
    foreach (sb.valid[i]) if (sb.valid[i]) live.push_back(i);
    if (live.size() > 0 && $urandom_range(0, 99) < 80)
      return sb.ids[live[$urandom_range(0, live.size() - 1)]];
    return $urandom;
  endfunction

  task automatic send_random(input logic [CMD_W-1:0] cmd);
    timer_cmd_t c;
    int         p;
    c.cmd = cmd;
    p = $urandom_range(0, 99);
    clock_now = clock_now + $urandom_range(0, 200);
    c.now = (p < 4) ? rand_time() : (p < 6) ? TIME_MAX : clock_now;
    c.id = pick_id();
    p = $urandom_range(0, 99);
    c.ivl = (p < 8) ? '0 : (p < 14) ? IVL_W'({$urandom, $urandom})
          : IVL_W'($urandom_range(1, 400));
    c.has_base = 1'($urandom_range(0, 1));
    p = $urandom_range(0, 99);
    c.base = (p < 5) ? rand_time() : (p < 8) ? TIME_MAX
           : clock_now - $urandom_range(0, 300);
    c.pol = ($urandom_range(0, 9) == 0) ? 2'd3 : POL_W'($urandom_range(0, 2));
    c.tag = TAG_W'($urandom);
    send_cmd(c);
  endtask

  initial begin
    logic [CMD_W-1:0] cmd;
    int               p;
    sb = new();
    calm = 0;
    clock_now = 1000;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, every command and policy
    send_fields(CMD_RUN,    0, 0, 0, 0, 0, POL_ONCE, 0);
    send_fields(CMD_ADD,    0, 0, 0, 1, 0, POL_ONCE, '1);
    send_fields(CMD_ADD,    0, 0, '1, 1, TIME_MAX, POL_FIXED, 16'h1234);
    send_fields(CMD_ADD,    50, 0, 30, 0, 0, 2'd2, 16'h0002);
    send_fields(CMD_ADD,    50, 0, 40, 0, 0, 2'd3, 16'h0003);
    send_fields(CMD_ADD,    10, 0, 0, 0, 0, POL_FIXED, 16'h0005);
    send_fields(CMD_ADD,    10, 0, 7, 1, 3, POL_FIXED, 16'h0006);
    send_fields(CMD_ADD,    60, 0, 20, 0, 0, POL_ONCE, 16'h0007);
    send_fields(CMD_MODIFY, 0, 32'd2, 5, 1, 100, POL_FIXED, 0);
    send_fields(CMD_MODIFY, 0, '1, 5, 0, 0, POL_ONCE, 0);
    send_fields(CMD_REMOVE, 0, '1, 0, 0, 0, POL_ONCE, 0);
    send_fields(CMD_RUN,    100, 0, 0, 0, 0, POL_ONCE, 0);
    send_fields(CMD_RUN,    1000, 0, 0, 0, 0, POL_ONCE, 0);
    send_fields(CMD_REMOVE, 0, 32'd6, 0, 0, 0, POL_ONCE, 0);
    send_fields(CMD_MODIFY, 0, 32'd4, '1, 1, TIME_MAX - 5, 2'd2, 0);
    send_fields(CMD_RUN,    TIME_MAX, 0, 0, 0, 0, POL_ONCE, 0);
    send_fields(CMD_RUN,    TIME_MAX, 0, 0, 0, 0, POL_ONCE, 0);
    send_fields(CMD_REMOVE, 0, 32'd2, 0, 0, 0, POL_ONCE, 0);
    send_fields(CMD_REMOVE, 0, 32'd2, 0, 0, 0, POL_ONCE, 0);

    for (int n = 0; n < 330; n++) begin
      calm = (n >= 200 && n < 280);
      if (n == 150) begin
        s_axis_tvalid_i <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
      if (n % 115 == 40) begin
        // fill the table past full, then advance time and run twice
        for (int j = 0; j < 34; j++) send_random(CMD_ADD);
        clock_now = clock_now + 5000;
        send_random(CMD_RUN);
        send_random(CMD_RUN);
      end
      p = $urandom_range(0, 99);
      cmd = (p < 35) ? CMD_ADD : (p < 55) ? CMD_MODIFY : (p < 70) ? CMD_REMOVE : CMD_RUN;
      send_random(cmd);
    end
    s_axis_tvalid_i <= 1'b0;
    calm = 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** timer_slot_scheduler: PASSED **");
    else
      $display("** timer_slot_scheduler: FAILED **");
    $finish;
  end

endmodule

[timer_slot_scheduler.f]
sv/tss_pkg.sv
sv/tss_mod.sv
sv/timer_slot_scheduler.sv
dv/timer_slot_scheduler_test.sv
